// ----- hw/rtl/pixel_histogram_engine_macros.svh -----
// Assertion macros shared by the histogram engine RTL.
// No dependencies; pulled in by files that carry concurrent assertions.
`ifndef PIXEL_HISTOGRAM_ENGINE_MACROS_SVH
`define PIXEL_HISTOGRAM_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PHE_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PHE_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- hw/rtl/phe_pkg.sv -----
// Package for the pixel histogram engine: sizes, codes, payload types.
// No dependencies; imported by every module of the block.
package phe_pkg;

   localparam int BIN_COUNT      = 256;
   localparam int COUNT_BITS     = 24;
   localparam int BIN_IDX_BITS   = $clog2(BIN_COUNT);
   localparam int READOUT_BITS   = 24;
   localparam int DIM_BITS       = 13;
   localparam int POS_BITS       = 12;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = DIM_BITS;

   localparam logic [COUNT_BITS-1:0]   COUNT_MAX   = {COUNT_BITS{1'b1}};
   localparam logic [READOUT_BITS-1:0] READOUT_MAX = {READOUT_BITS{1'b1}};
   localparam logic [DIM_BITS-1:0]     DIM_MAX      = 13'd4096;
   localparam logic [DIM_BITS-1:0]     WIDTH_RESET  = 13'd640;
   localparam logic [DIM_BITS-1:0]     HEIGHT_RESET = 13'd480;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   typedef enum logic [1:0] {
      OP_PIXEL   = 2'd0,
      OP_READ    = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_READOUT    = 2'd0,
      KIND_FRAME_DONE = 2'd1,
      KIND_REJECTED   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [1:0]              result_kind;
      logic [READOUT_BITS-1:0] bin_count;
   } rsp_type;

   // Frame position verdict for the pixel sitting in the work stage.
   typedef struct packed {
      logic frame_done;
      logic rejected;
   } frame_status_type;

   // Zero behaves as one, anything above 4096 as 4096.
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      r = v;
      if (v == '0) begin
         r = 13'd1;
      end else if (v > DIM_MAX) begin
         r = DIM_MAX;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/phe_bin_store.sv -----
// Bin count memory with per-entry valid bits and write-to-read forwarding.
// Depends on phe_pkg.
module phe_bin_store
   import phe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [BIN_IDX_BITS-1:0] rd_addr,
   input  logic                    wr_en,
   input  logic [BIN_IDX_BITS-1:0] wr_addr,
   input  logic [COUNT_BITS-1:0]   wr_data,
   output logic [COUNT_BITS-1:0]   old_count
);

   logic [COUNT_BITS-1:0] mem [BIN_COUNT];
   logic [BIN_COUNT-1:0]  valid_ff;
   logic [COUNT_BITS-1:0] rdata_ff;
   logic                  rd_valid_ff;
   logic                  fwd_hit_ff;
   logic [COUNT_BITS-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff    <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // Entries not yet written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
            // write landing on the same edge as the read: take its data
            fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   always_comb begin
      if (fwd_hit_ff) begin
         old_count = fwd_data_ff;
      end else if (rd_valid_ff) begin
         old_count = rdata_ff;
      end else begin
         old_count = '0;
      end
   end

endmodule

// ----- hw/rtl/phe_frame_ctrl.sv -----
// Raster column/row counters and frame-full flag.
// Depends on phe_pkg.
module phe_frame_ctrl
   import phe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                pixel,
   input  logic                advance,
   input  logic                restart,
   input  logic [DIM_BITS-1:0] image_width,
   input  logic [DIM_BITS-1:0] image_height,
   output frame_status_type    status
);

   logic [POS_BITS-1:0] col_ff, col_in;
   logic [POS_BITS-1:0] row_ff, row_in;
   logic                full_ff, full_in;
   logic [DIM_BITS-1:0] width_eff, height_eff;
   logic                col_last, row_last;

   assign width_eff  = clamp_dim(image_width);
   assign height_eff = clamp_dim(image_height);
   assign col_last   = ({1'b0, col_ff} + 13'd1) >= width_eff;
   assign row_last   = ({1'b0, row_ff} + 13'd1) >= height_eff;

   always_comb begin
      status.frame_done = pixel && !full_ff && col_last && row_last;
      status.rejected   = pixel && full_ff;
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      full_in = full_ff;
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         full_in = 1'b0;
      end else if (advance && pixel && !full_ff) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in  = '0;
               full_in = 1'b1;
            end else begin
               row_in = row_ff + 12'd1;
            end
         end else begin
            col_in = col_ff + 12'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         full_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         full_ff <= full_in;
      end
   end

endmodule

// ----- hw/rtl/pixel_histogram_engine.sv -----
// Top level of the 256-bin grey-level histogram engine.
// Depends on phe_pkg, phe_bin_store, phe_frame_ctrl and the macros header.
//
//   port group  dir  contents
//   req_*       in   transaction: operation, pixel_value (valid/ready)
//   rsp_*       out  transaction: result_kind, bin_count (valid/ready)
//   csr_*       in   register write: index 0 image_width, 1 image_height
//
// One transaction per cycle unless a held result stalls the work stage.
// The bin read is issued at acceptance, the read-modify-write finishes in the
// work stage, limited by the bin memory's one read port and one write port.
// Synchronous reset clears all bins via valid bits at once; no clearing pass.
// A stalled result register stalls the work stage only when that stage has
// a result of its own; transactions without a result keep flowing.
`include "pixel_histogram_engine_macros.svh"

module pixel_histogram_engine
   import phe_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // configuration registers
   logic [DIM_BITS-1:0] width_ff, height_ff;

   // work stage
   logic    s1_valid_ff;
   req_type s1_data_ff;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic                    req_fire;
   logic                    s1_fire;
   logic                    s1_has_result;
   logic                    out_free;
   logic                    op_pixel, op_read, op_restart;
   logic                    in_range;
   logic [BIN_IDX_BITS-1:0] s1_addr;
   logic [COUNT_BITS-1:0]   old_count;
   logic [COUNT_BITS-1:0]   wr_data;
   logic                    wr_en;
   logic [READOUT_BITS-1:0] readout;
   frame_status_type        status;
   rsp_type                 rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign op_pixel   = s1_data_ff.operation == OP_PIXEL;
   assign op_read    = s1_data_ff.operation == OP_READ;
   assign op_restart = s1_data_ff.operation == OP_RESTART;
   // bin indexes past the store count nowhere and read as zero
   assign in_range   = 32'(s1_data_ff.pixel_value) < BIN_COUNT;
   assign s1_addr    = BIN_IDX_BITS'(s1_data_ff.pixel_value);

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign s1_has_result = s1_valid_ff &&
                          (op_read || status.frame_done || status.rejected);
   assign s1_fire       = s1_valid_ff && (!s1_has_result || out_free);
   assign req_ready     = !s1_valid_ff || s1_fire;
   assign req_fire      = req_valid && req_ready;

   phe_frame_ctrl u_frame (
      .clock        (clock),
      .reset        (reset),
      .pixel        (s1_valid_ff && op_pixel),
      .advance      (s1_fire),
      .restart      (s1_fire && op_restart),
      .image_width  (width_ff),
      .image_height (height_ff),
      .status       (status)
   );

   // counting saturates; a read clears the bin
   always_comb begin
      wr_en   = 1'b0;
      wr_data = '0;
      if (s1_fire && in_range) begin
         if (op_pixel && !status.rejected) begin
            wr_en   = 1'b1;
            wr_data = (old_count == COUNT_MAX) ? old_count : old_count + 1'b1;
         end else if (op_read) begin
            wr_en = 1'b1;
         end
      end
   end

   phe_bin_store u_bins (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_addr   (BIN_IDX_BITS'(req_data.pixel_value)),
      .wr_en     (wr_en),
      .wr_addr   (s1_addr),
      .wr_data   (wr_data),
      .old_count (old_count)
   );

   // clamp to the readout field for wide counters
   always_comb begin
      readout = '0;
      if (in_range) begin
         if (32'(old_count) > 32'(READOUT_MAX)) begin
            readout = READOUT_MAX;
         end else begin
            readout = READOUT_BITS'(old_count);
         end
      end
   end

   always_comb begin
      rsp_in.result_kind = KIND_READOUT;
      rsp_in.bin_count   = '0;
      if (status.rejected) begin
         rsp_in.result_kind = KIND_REJECTED;
      end else if (status.frame_done) begin
         rsp_in.result_kind = KIND_FRAME_DONE;
      end else begin
         rsp_in.bin_count = readout;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_data;
      end
      if (s1_fire && s1_has_result) begin
         rsp_data_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire && s1_has_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PHE_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_valid && req_ready, s1_valid_ff, "accepted transaction did not reach work stage")
   `PHE_ASSERT_NOW(a_no_result_overwrite, clock, reset, s1_fire && s1_has_result, !rsp_valid_ff || rsp_ready, "result retired over an untaken result")
   `PHE_ASSERT_NOW(a_count_only_readout, clock, reset, rsp_valid_ff && (rsp_data_ff.result_kind != KIND_READOUT), rsp_data_ff.bin_count == '0, "nonzero count on a non-readout result")

endmodule
